FILE: design/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

  localparam int CW    = 32;
  localparam int OCW   = 33;
  localparam int AW    = 64;
  localparam int AH    = 32;
  localparam int HW    = 66;
  localparam int HMW   = 65;
  localparam int KW    = 67;
  localparam int KMW   = 66;
  localparam int LO    = 33;
  localparam int PW    = 130;
  localparam int QW    = 132;
  localparam int RADW  = 130;
  localparam int ROOTW = 65;
  localparam int REMW  = 67;
  localparam int NSW   = 68;
  localparam int NMW   = 67;
  localparam int QB    = 33;
  localparam int CFG_AW = 2;

  localparam int LANE_NEAR = 0;
  localparam int LANE_FAR  = 1;

  localparam logic signed [CW-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] T_MIN = 32'sh8000_0000;
  localparam logic [QB-1:0] QPOS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0] QNEG_LIM = 33'h0_8000_0000;

  typedef enum logic [1:0] {
    ST_MISS  = 2'd0,
    ST_HIT   = 2'd1,
    ST_DEGEN = 2'd2
  } hit_status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] ray_origin_x;
    logic signed [CW-1:0] ray_origin_y;
    logic signed [CW-1:0] ray_origin_z;
    logic signed [CW-1:0] ray_dir_x;
    logic signed [CW-1:0] ray_dir_y;
    logic signed [CW-1:0] ray_dir_z;
  } ray_in_t;

  typedef struct packed {
    hit_status_t          hit_status;
    logic signed [CW-1:0] t_near;
    logic signed [CW-1:0] t_far;
  } hit_out_t;

  typedef struct packed {
    logic                 vld;
    hit_status_t          status;
    logic [AW-1:0]        a;
    logic signed [HW-1:0] h;
    logic [RADW-1:0]      rad;
    logic [REMW-1:0]      rem;
    logic [ROOTW-1:0]     root;
  } sq_bus_t;

  typedef struct packed {
    logic                   vld;
    hit_status_t            status;
    logic [AW-1:0]          a;
    logic [1:0]             neg;
    logic [1:0]             ovf;
    logic [1:0][AW-1:0]     r;
    logic [1:0][QB-1:0]     q;
    logic [1:0][QB-1:0]     b;
  } dv_bus_t;

endpackage
`default_nettype wire

FILE: design/rsi_front.sv
`default_nettype none
module rsi_front
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire ray_in_t              ray_i,
  input  wire logic signed [CW-1:0] ctr_i [3],
  output sq_bus_t                   sq_o
);

  localparam logic signed [KW-1:0] K_ONE = KW'(1) << (2 * FRAC_BITS);

  logic signed [CW-1:0] org [3];
  logic signed [CW-1:0] dir [3];

  logic [6:0] vld_r;

  logic signed [CW-1:0]      d_r   [3];
  logic signed [OCW-1:0]     oc_r  [3];
  logic signed [2*CW-1:0]    dd_r  [3];
  logic signed [CW+OCW-1:0]  doc_r [3];
  logic signed [2*OCW-1:0]   oo_r  [3];

  logic [AW-1:0]        a3_r, a4_r, a5_r, a6_r, a7_r;
  logic signed [HW-1:0] h3_r, h4_r, h5_r, h6_r, h7_r;
  logic signed [KW-1:0] k3_r;
  logic [HMW-1:0]       hm_r;
  logic [KMW-1:0]       km_r;
  logic                 ks4_r, ks5_r, ks6_r;

  logic [2*LO-1:0]      p_hll_r;
  logic [LO+HMW-LO-1:0] p_hlh_r;
  logic [2*(HMW-LO)-1:0] p_hhh_r;
  logic [AH+LO-1:0]     p_akll_r, p_aklh_r, p_akhl_r, p_akhh_r;

  logic [PW-1:0]        hh_r, ak_r;
  logic signed [QW-1:0] q_r;
  hit_status_t          st_r;

  assign org[0] = ray_i.ray_origin_x;
  assign org[1] = ray_i.ray_origin_y;
  assign org[2] = ray_i.ray_origin_z;
  assign dir[0] = ray_i.ray_dir_x;
  assign dir[1] = ray_i.ray_dir_y;
  assign dir[2] = ray_i.ray_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= dir[i];
        oc_r[i]  <= OCW'(org[i]) - OCW'(ctr_i[i]);
        dd_r[i]  <= d_r[i] * d_r[i];
        doc_r[i] <= d_r[i] * oc_r[i];
        oo_r[i]  <= oc_r[i] * oc_r[i];
      end

      a3_r <= AW'($unsigned(dd_r[0])) + AW'($unsigned(dd_r[1])) + AW'($unsigned(dd_r[2]));
      h3_r <= HW'(doc_r[0]) + HW'(doc_r[1]) + HW'(doc_r[2]);
      k3_r <= KW'(oo_r[0]) + KW'(oo_r[1]) + KW'(oo_r[2]) - K_ONE;

      a4_r  <= a3_r;
      h4_r  <= h3_r;
      hm_r  <= h3_r[HW-1] ? HMW'(-h3_r) : HMW'(h3_r);
      km_r  <= k3_r[KW-1] ? KMW'(-k3_r) : KMW'(k3_r);
      ks4_r <= k3_r[KW-1];

      a5_r     <= a4_r;
      h5_r     <= h4_r;
      ks5_r    <= ks4_r;
      p_hll_r  <= hm_r[LO-1:0] * hm_r[LO-1:0];
      p_hlh_r  <= hm_r[LO-1:0] * hm_r[HMW-1:LO];
      p_hhh_r  <= hm_r[HMW-1:LO] * hm_r[HMW-1:LO];
      p_akll_r <= a4_r[AH-1:0] * km_r[LO-1:0];
      p_aklh_r <= a4_r[AH-1:0] * km_r[KMW-1:LO];
      p_akhl_r <= a4_r[AW-1:AH] * km_r[LO-1:0];
      p_akhh_r <= a4_r[AW-1:AH] * km_r[KMW-1:LO];

      a6_r  <= a5_r;
      h6_r  <= h5_r;
      ks6_r <= ks5_r;
      hh_r  <= (PW'(p_hhh_r) << (2 * LO)) + (PW'(p_hlh_r) << (LO + 1)) + PW'(p_hll_r);
      ak_r  <= (PW'(p_akhh_r) << (AH + LO)) + (PW'(p_aklh_r) << LO)
             + (PW'(p_akhl_r) << AH) + PW'(p_akll_r);

      a7_r <= a6_r;
      h7_r <= h6_r;
      q_r  <= ks6_r ? $signed(QW'(hh_r) + QW'(ak_r)) : $signed(QW'(hh_r) - QW'(ak_r));
      if (a6_r == '0) begin
        st_r <= ST_DEGEN;
      end else if (ks6_r == 1'b0 && hh_r < ak_r) begin
        st_r <= ST_MISS;
      end else begin
        st_r <= ST_HIT;
      end
    end
  end

  always_comb begin
    sq_o        = '0;
    sq_o.vld    = vld_r[6];
    sq_o.status = st_r;
    sq_o.a      = a7_r;
    sq_o.h      = h7_r;
    sq_o.rad    = q_r[RADW-1:0];
  end

endmodule
`default_nettype wire

FILE: design/rsi_sqrt_cell.sv
`default_nettype none
module rsi_sqrt_cell
  import rsi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire sq_bus_t bus_i,
  output sq_bus_t      bus_o
);

  sq_bus_t         bus_r, bus_nxt;
  logic [REMW+1:0] cat;
  logic [REMW+1:0] trial;

  always_comb begin
    bus_nxt     = bus_i;
    cat         = {bus_i.rem, bus_i.rad[RADW-1 -: 2]};
    trial       = (REMW + 2)'({bus_i.root, 2'b01});
    bus_nxt.rad = bus_i.rad << 2;
    if (cat >= trial) begin
      bus_nxt.rem  = REMW'(cat - trial);
      bus_nxt.root = {bus_i.root[ROOTW-2:0], 1'b1};
    end else begin
      bus_nxt.rem  = cat[REMW-1:0];
      bus_nxt.root = {bus_i.root[ROOTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule
`default_nettype wire

FILE: design/rsi_div_cell.sv
`default_nettype none
module rsi_div_cell
  import rsi_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire dv_bus_t bus_i,
  output dv_bus_t      bus_o
);

  dv_bus_t     bus_r, bus_nxt;
  logic [AW:0] cat [2];

  always_comb begin
    bus_nxt = bus_i;
    for (int l = 0; l < 2; l++) begin
      cat[l]        = {bus_i.r[l], bus_i.b[l][QB-1]};
      bus_nxt.b[l]  = {bus_i.b[l][QB-2:0], 1'b0};
      if (cat[l] >= {1'b0, bus_i.a}) begin
        bus_nxt.r[l] = AW'(cat[l] - {1'b0, bus_i.a});
        bus_nxt.q[l] = {bus_i.q[l][QB-2:0], 1'b1};
      end else begin
        bus_nxt.r[l] = cat[l][AW-1:0];
        bus_nxt.q[l] = {bus_i.q[l][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule
`default_nettype wire

FILE: design/ray_sphere_intersect_unit.sv
// Ray against unit sphere intersection unit.
// Input channel: in_valid/in_ready/in_data carries one ray (origin and
// direction, signed fixed point) per beat. Output channel:
// out_valid/out_ready/out_data carries one result beat per ray, in order:
// hit status plus near and far ray parameters, saturated to 32 bits.
// The user must write the sphere centre through cfg_we/cfg_addr/cfg_wdata
// only while the unit is idle; the unit does not enforce this. A write
// takes effect at once and has no read-back. Each ray passes seven stages
// that form the quadratic, 65 cells of the square-root chain that produce
// one root bit each, three stages that set up the division and 33 divider
// cells that produce one quotient bit each, then the output register. One
// ray is accepted every cycle while the receiver takes results. When
// out_valid is high and out_ready low the whole pipeline holds and
// in_ready falls in the same cycle. Reset clears all valid flags and the
// centre registers; the unit is ready in the first cycle after reset.
`default_nettype none
module ray_sphere_intersect_unit
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ray_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hit_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CW-1:0]     cfg_wdata
);

  localparam int NW   = NMW + FRAC_BITS;
  localparam int HIW  = NW - QB;
  localparam int CMPW = (HIW > AW) ? HIW : AW;

  logic                 en;
  logic signed [CW-1:0] ctr_r [3];

  sq_bus_t sq_bus [ROOTW+1];
  dv_bus_t dv_bus [QB+1];

  logic                  p1_vld_r, p2_vld_r;
  hit_status_t           p1_st_r, p2_st_r;
  logic [AW-1:0]         p1_a_r, p2_a_r;
  logic signed [NSW-1:0] p1_n_r [2];
  logic [NMW-1:0]        p2_mag_r [2];
  logic [1:0]            p2_neg_r;
  logic [NW-1:0]         nfull [2];
  dv_bus_t               p3_r, p3_nxt;

  logic                  out_valid_r;
  hit_out_t              out_data_r, out_nxt;
  logic signed [CW-1:0]  t_res [2];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CENTER_X: ctr_r[0] <= cfg_wdata;
        REG_CENTER_Y: ctr_r[1] <= cfg_wdata;
        REG_CENTER_Z: ctr_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rsi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .ray_i (in_data),
    .ctr_i (ctr_r),
    .sq_o  (sq_bus[0])
  );

  for (genvar i = 0; i < ROOTW; i++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bus_i (sq_bus[i]),
      .bus_o (sq_bus[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_r.vld <= 1'b0;
    end else if (en) begin
      p1_vld_r <= sq_bus[ROOTW].vld;
      p2_vld_r <= p1_vld_r;
      p3_r     <= p3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_st_r <= sq_bus[ROOTW].status;
      p1_a_r  <= sq_bus[ROOTW].a;
      p1_n_r[LANE_NEAR] <= -NSW'(sq_bus[ROOTW].h)
                         - NSW'($signed({1'b0, sq_bus[ROOTW].root}));
      p1_n_r[LANE_FAR]  <= -NSW'(sq_bus[ROOTW].h)
                         + NSW'($signed({1'b0, sq_bus[ROOTW].root}));
      p2_st_r <= p1_st_r;
      p2_a_r  <= p1_a_r;
      for (int l = 0; l < 2; l++) begin
        p2_neg_r[l] <= p1_n_r[l][NSW-1];
        p2_mag_r[l] <= p1_n_r[l][NSW-1] ? NMW'(-p1_n_r[l]) : NMW'(p1_n_r[l]);
      end
    end
  end

  always_comb begin
    p3_nxt        = '0;
    p3_nxt.vld    = p2_vld_r;
    p3_nxt.status = p2_st_r;
    p3_nxt.a      = p2_a_r;
    p3_nxt.neg    = p2_neg_r;
    for (int l = 0; l < 2; l++) begin
      nfull[l]       = {p2_mag_r[l], {FRAC_BITS{1'b0}}};
      p3_nxt.ovf[l]  = CMPW'(nfull[l][NW-1:QB]) >= CMPW'(p2_a_r);
      p3_nxt.r[l]    = AW'(nfull[l][NW-1:QB]);
      p3_nxt.b[l]    = nfull[l][QB-1:0];
    end
  end

  assign dv_bus[0] = p3_r;

  for (genvar j = 0; j < QB; j++) begin : g_div
    rsi_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bus_i (dv_bus[j]),
      .bus_o (dv_bus[j+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_bus[QB].neg[l]) begin
        if (dv_bus[QB].ovf[l] || dv_bus[QB].q[l] > QNEG_LIM) begin
          t_res[l] = T_MIN;
        end else begin
          t_res[l] = -$signed(dv_bus[QB].q[l][CW-1:0]);
        end
      end else begin
        if (dv_bus[QB].ovf[l] || dv_bus[QB].q[l] > QPOS_LIM) begin
          t_res[l] = T_MAX;
        end else begin
          t_res[l] = $signed(dv_bus[QB].q[l][CW-1:0]);
        end
      end
    end
    out_nxt            = '0;
    out_nxt.hit_status = dv_bus[QB].status;
    if (dv_bus[QB].status == ST_HIT) begin
      out_nxt.t_near = t_res[LANE_NEAR];
      out_nxt.t_far  = t_res[LANE_FAR];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_bus[QB].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_zero_unless_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hit_status != ST_HIT)
      |-> (out_data_r.t_near == '0 && out_data_r.t_far == '0))
    else $error("non-hit result carries a nonzero parameter");

  a_near_le_far: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hit_status == ST_HIT)
      |-> (out_data_r.t_near <= out_data_r.t_far))
    else $error("near parameter exceeds far parameter");

  a_stall_holds_div: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_bus[QB]))
    else $error("divider chain moved during a stall");

  a_stall_holds_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_bus[ROOTW]))
    else $error("square-root chain moved during a stall");

endmodule
`default_nettype wire

FILE: tb/ray_sphere_intersect_unit_test.sv
`timescale 1ns / 1ps
module ray_sphere_intersect_unit_test
  import rsi_pkg::*;
();

  localparam int FRAC = 16;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hit_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_CENTER_X;
  logic [CW-1:0] cfg_wdata = '0;

  logic signed [CW-1:0] centre [3];
  ray_in_t rays_pending [$];
  hit_out_t hits_due [$];
  int send_idle = 32;
  int take_idle = 52;
  int errs = 0;
  int cycles = 0;
  bit ray_taken = 1'b0;

  ray_sphere_intersect_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic signed [CW-1:0] scale_param(logic signed [191:0] num,
                                                       logic [191:0] a);
    logic [191:0] mag;
    logic [191:0] quo;
    mag = (num < 0) ? 192'(-num) : 192'(num);
    quo = (mag << FRAC) / a;
    if (num < 0) begin
      if (quo > 192'h8000_0000) return T_MIN;
      return -CW'(quo);
    end
    if (quo > 192'h7FFF_FFFF) return T_MAX;
    return CW'(quo);
  endfunction

  function automatic hit_out_t predict_hit(ray_in_t r);
    logic signed [191:0] a, h, k, d, oc, disc, s;
    logic [191:0] root, trial;
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    hit_out_t res;
    org = '{r.ray_origin_x, r.ray_origin_y, r.ray_origin_z};
    dir = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
    a = 0; h = 0; k = 0;
    for (int i = 0; i < 3; i++) begin
      d = dir[i];
      oc = 192'(org[i]) - 192'(centre[i]);
      a += d * d;
      h += d * oc;
      k += oc * oc;
    end
    k -= 192'(1) << (2 * FRAC);
    res = '{ST_MISS, '0, '0};
    if (a == 0) begin
      res.hit_status = ST_DEGEN;
      return res;
    end
    disc = h * h - a * k;
    if (disc < 0) return res;
    root = 0;
    for (int i = 95; i >= 0; i--) begin
      trial = root | (192'(1) << i);
      if (trial * trial <= 192'(disc)) root = trial;
    end
    s = root;
    res.hit_status = ST_HIT;
    res.t_near = scale_param(-h - s, a);
    res.t_far = scale_param(-h + s, a);
    return res;
  endfunction

  always @(posedge clk) begin
    hit_out_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      hits_due = {hits_due, predict_hit(in_data)};
      ray_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        errs++;
      end else begin
        want = hits_due.pop_front();
        if (out_data.hit_status !== want.hit_status) begin
          $error("hit_status expected %0d actual %0d", want.hit_status, out_data.hit_status);
          errs++;
        end
        if (out_data.t_near !== want.t_near) begin
          $error("t_near expected %0d actual %0d", want.t_near, out_data.t_near);
          errs++;
        end
        if (out_data.t_far !== want.t_far) begin
          $error("t_far expected %0d actual %0d", want.t_far, out_data.t_far);
          errs++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || ray_taken)) begin
      ray_taken = 1'b0;
      if (rays_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_data <= rays_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= take_idle);
  end

  task automatic write_centre(cfg_reg_t idx, logic signed [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    centre[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_centre(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    write_centre(REG_CENTER_X, x);
    write_centre(REG_CENTER_Y, y);
    write_centre(REG_CENTER_Z, z);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (rays_pending.size() > 0 || in_valid || hits_due.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_in_t r;
    r = '{ox, oy, oz, dx, dy, dz};
    rays_pending = {rays_pending, r};
  endtask

  function automatic int near_val(int base, int span);
    return base + $urandom_range(2 * span) - span;
  endfunction

  task automatic queue_random(int count);
    ray_in_t r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(9) == 0) {r.ray_dir_x, r.ray_dir_y, r.ray_dir_z} = '0;
      end else begin
        r.ray_origin_x = near_val(centre[0], 1 << 19);
        r.ray_origin_y = near_val(centre[1], 1 << 19);
        r.ray_origin_z = near_val(centre[2], 1 << 19);
        r.ray_dir_x = near_val(0, 1 << $urandom_range(4, 20));
        r.ray_dir_y = near_val(0, 1 << $urandom_range(4, 20));
        r.ray_dir_z = near_val(0, 1 << $urandom_range(4, 20));
      end
      rays_pending = {rays_pending, r};
    end
  endtask

  initial begin
    centre = '{0, 0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_ray(0, 0, 0, 0, 0, 0);
    queue_ray(-3 << 16, 0, 0, 1 << 16, 0, 0);
    queue_ray(-3 << 16, 2 << 16, 0, 1 << 16, 0, 0);
    queue_ray(-3 << 16, 1 << 16, 0, 1 << 16, 0, 0);
    queue_ray(0, 0, -5 << 16, 0, 0, 1);
    queue_ray(0, 0, 5 << 16, 0, 0, -1);
    queue_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    queue_ray(0, 0, 0, 32'h8000_0000, 1, -1);
    queue_ray(1 << 14, 0, 0, 0, 1 << 16, 0);
    queue_ray(-1, -1, -1, -1, -1, -1);
    drain();

    set_centre(32'h7FFF_FFFF, 32'h8000_0000, 0);
    queue_ray(32'h7FFF_FFFF, 32'h8000_0000, -2 << 16, 0, 0, 1 << 16);
    queue_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 1 << 16, -1 << 16, 0);
    queue_ray(32'h7FFF_FFFF, 32'h8000_0000 + (1 << 16), 0, 1 << 16, 0, 0);
    queue_random(200);
    drain();

    send_idle = 52;
    take_idle = 32;
    set_centre(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(250);
    drain();

    send_idle = 0;
    take_idle = 0;
    set_centre($urandom_range(1 << 20), -(1 << 18), 3 << 16);
    queue_random(250);
    drain();
    set_centre(0, 0, 0);
    queue_random(240);
    drain();

    repeat (120) @(posedge clk);
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
